>>> rtl/core/sprp_pkg.sv
// Package for the servo packet receive parser.
// Holds the parse phase type, the result event codes and the frame constants.
// No dependencies.
package sprp_pkg;

    typedef enum logic [3:0] {
        PH_HUNT      = 4'd0,
        PH_HDR_FF    = 4'd1,
        PH_HDR_FD    = 4'd2,
        PH_HDR_00    = 4'd3,
        PH_ID        = 4'd4,
        PH_LEN_LO    = 4'd5,
        PH_LEN_HI    = 4'd6,
        PH_INSTR     = 4'd7,
        PH_PARAM     = 4'd8,
        PH_CRC_LO    = 4'd9,
        PH_CRC_HI    = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        EV_PARAM = 2'd0,
        EV_DONE  = 2'd1,
        EV_ABORT = 2'd2
    } event_t;

    localparam logic       KIND_BYTE    = 1'b0;
    localparam logic       KIND_IDLE    = 1'b1;
    localparam logic [7:0] HDR_BYTE_FF  = 8'hFF;
    localparam logic [7:0] HDR_BYTE_FD  = 8'hFD;
    localparam logic [7:0] HDR_BYTE_00  = 8'h00;
    localparam logic [15:0] MIN_LENGTH  = 16'd3;
    localparam logic [15:0] CRC_BYTES   = 16'd2;

    localparam logic [7:0] FIRST_ID_RESET  = 8'd1;
    localparam logic [7:0] SECOND_ID_RESET = 8'd2;

    // Register indexes on the configuration port.
    localparam logic REG_FIRST_ID  = 1'b0;
    localparam logic REG_SECOND_ID = 1'b1;

endpackage

>>> rtl/core/servo_packet_receive_parser.sv
// Servo packet receive parser: top level, a single module.
// Depends on sprp_pkg for the phase type, event codes and frame constants.
//
// Usage
// The input channel (s_valid/s_ready) carries one request per received serial
// event: s_kind is 0 for a byte in s_byte_value, 1 for an idle line. The
// parser hunts for the header FF FF FD 00, checks the ID against the two
// configured IDs, reads a little-endian length, the instruction, the
// parameter bytes and a two-byte CRC, which is reported but not checked.
// The result channel (m_valid/m_ready) carries one request per parameter
// byte (with its index), one completion request per frame (ID, instruction,
// parameter count and received CRC) and one abort request whenever a header
// byte, the ID or the length is wrong, or the line goes idle mid-frame.
// A request is registered in the input register on acceptance; the parsing
// stage puts its result, if any, in the output register. Throughput is one
// request per cycle unless the receiver stalls; the input register takes
// a new request even while a result waits, if the output register drains.
// Reset (aresetn, synchronous, active low) returns the parser to hunting,
// clears its frame state and loads the ID registers with 1 and 2.
// When the receiver stalls, the output register holds its result, the
// parsing stage waits, and s_ready falls once the input register is full.
// The IDs are written over the APB-style port at byte addresses 0 and 4.
module servo_packet_receive_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_byte_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic [7:0]  m_servo_id,
    output logic [7:0]  m_instruction_code,
    output logic [15:0] m_param_index,
    output logic [7:0]  m_param_byte,
    output logic [15:0] m_param_count,
    output logic [15:0] m_crc_received,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [7:0] first_id_reg;
    logic [7:0] second_id_reg;
    logic       cfg_write;

    // Input register.
    logic       in_vld_reg, in_vld_next;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;

    // Parser state.
    sprp_pkg::phase_t phase_reg, phase_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] pidx_reg, pidx_next;
    logic [7:0]  fid_reg, fid_next;
    logic [7:0]  finstr_reg, finstr_next;
    logic [15:0] fcount_reg, fcount_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    // Output register.
    logic        out_vld_reg, out_vld_next;
    logic [1:0]  out_ev_reg, out_ev_next;
    logic [7:0]  out_id_reg, out_id_next;
    logic [7:0]  out_instr_reg, out_instr_next;
    logic [15:0] out_pidx_reg, out_pidx_next;
    logic [7:0]  out_pbyte_reg, out_pbyte_next;
    logic [15:0] out_count_reg, out_count_next;
    logic [15:0] out_crc_reg, out_crc_next;

    logic        advance;
    logic        process;
    logic        emit;
    logic [15:0] length_full;
    logic [15:0] remain_dec;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high, so no wait states are ever inserted.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_id_reg  <= sprp_pkg::FIRST_ID_RESET;
            second_id_reg <= sprp_pkg::SECOND_ID_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == sprp_pkg::REG_FIRST_ID) begin
                first_id_reg <= pwdata[7:0];
            end else begin
                second_id_reg <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == sprp_pkg::REG_FIRST_ID) begin
            prdata = {24'd0, first_id_reg};
        end else begin
            prdata = {24'd0, second_id_reg};
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The parsing stage moves whenever the output register is
    // empty or being drained; the input register refills in the same cycle.
    // ------------------------------------------------------------------
    assign advance = !out_vld_reg || m_ready;
    assign process = in_vld_reg && advance;
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (process) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Parser: one state update per request.
    // ------------------------------------------------------------------
    assign length_full = {in_byte_reg, remain_reg[7:0]};
    assign remain_dec  = remain_reg - 16'd1;

    always_comb begin
        phase_next     = phase_reg;
        remain_next    = remain_reg;
        pidx_next      = pidx_reg;
        fid_next       = fid_reg;
        finstr_next    = finstr_reg;
        fcount_next    = fcount_reg;
        crc_lo_next    = crc_lo_reg;
        emit           = 1'b0;
        out_ev_next    = sprp_pkg::EV_ABORT;
        out_pidx_next  = 16'd0;
        out_pbyte_next = 8'd0;
        out_count_next = 16'd0;
        out_crc_next   = 16'd0;

        if (process) begin
            if (phase_reg == sprp_pkg::PH_HUNT) begin
                // Noise and idle marks are dropped while hunting.
                if (in_kind_reg == sprp_pkg::KIND_BYTE &&
                    in_byte_reg == sprp_pkg::HDR_BYTE_FF) begin
                    fid_next    = 8'd0;
                    finstr_next = 8'd0;
                    pidx_next   = 16'd0;
                    phase_next  = sprp_pkg::PH_HDR_FF;
                end
            end else if (in_kind_reg == sprp_pkg::KIND_IDLE) begin
                // Line went idle inside a frame.
                emit       = 1'b1;
                phase_next = sprp_pkg::PH_HUNT;
            end else begin
                case (phase_reg)
                    sprp_pkg::PH_HDR_FF: begin
                        if (in_byte_reg != sprp_pkg::HDR_BYTE_FF) begin
                            emit       = 1'b1;
                            phase_next = sprp_pkg::PH_HUNT;
                        end else begin
                            phase_next = sprp_pkg::PH_HDR_FD;
                        end
                    end
                    sprp_pkg::PH_HDR_FD: begin
                        if (in_byte_reg != sprp_pkg::HDR_BYTE_FD) begin
                            emit       = 1'b1;
                            phase_next = sprp_pkg::PH_HUNT;
                        end else begin
                            phase_next = sprp_pkg::PH_HDR_00;
                        end
                    end
                    sprp_pkg::PH_HDR_00: begin
                        if (in_byte_reg != sprp_pkg::HDR_BYTE_00) begin
                            emit       = 1'b1;
                            phase_next = sprp_pkg::PH_HUNT;
                        end else begin
                            phase_next = sprp_pkg::PH_ID;
                        end
                    end
                    sprp_pkg::PH_ID: begin
                        if (in_byte_reg != first_id_reg && in_byte_reg != second_id_reg) begin
                            emit       = 1'b1;
                            phase_next = sprp_pkg::PH_HUNT;
                        end else begin
                            fid_next   = in_byte_reg;
                            phase_next = sprp_pkg::PH_LEN_LO;
                        end
                    end
                    sprp_pkg::PH_LEN_LO: begin
                        remain_next = {8'd0, in_byte_reg};
                        phase_next  = sprp_pkg::PH_LEN_HI;
                    end
                    sprp_pkg::PH_LEN_HI: begin
                        if (length_full < sprp_pkg::MIN_LENGTH) begin
                            emit       = 1'b1;
                            phase_next = sprp_pkg::PH_HUNT;
                        end else begin
                            remain_next = length_full;
                            fcount_next = length_full - sprp_pkg::MIN_LENGTH;
                            phase_next  = sprp_pkg::PH_INSTR;
                        end
                    end
                    sprp_pkg::PH_INSTR: begin
                        finstr_next = in_byte_reg;
                        remain_next = remain_dec;
                        if (remain_dec == sprp_pkg::CRC_BYTES) begin
                            phase_next = sprp_pkg::PH_CRC_LO;
                        end else begin
                            phase_next = sprp_pkg::PH_PARAM;
                        end
                    end
                    sprp_pkg::PH_PARAM: begin
                        emit           = 1'b1;
                        out_ev_next    = sprp_pkg::EV_PARAM;
                        out_pidx_next  = pidx_reg;
                        out_pbyte_next = in_byte_reg;
                        pidx_next      = pidx_reg + 16'd1;
                        remain_next    = remain_dec;
                        if (remain_dec == sprp_pkg::CRC_BYTES) begin
                            phase_next = sprp_pkg::PH_CRC_LO;
                        end
                    end
                    sprp_pkg::PH_CRC_LO: begin
                        crc_lo_next = in_byte_reg;
                        phase_next  = sprp_pkg::PH_CRC_HI;
                    end
                    sprp_pkg::PH_CRC_HI: begin
                        emit           = 1'b1;
                        out_ev_next    = sprp_pkg::EV_DONE;
                        out_count_next = fcount_reg;
                        out_crc_next   = {in_byte_reg, crc_lo_reg};
                        phase_next     = sprp_pkg::PH_HUNT;
                    end
                    default: begin
                        // Unused phase codes fall back to hunting silently.
                        phase_next = sprp_pkg::PH_HUNT;
                    end
                endcase
            end
        end
    end

    // ID and instruction are reported as they stood before this byte.
    assign out_id_next    = fid_reg;
    assign out_instr_next = finstr_reg;

    always_comb begin
        if (process) begin
            out_vld_next = emit;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= sprp_pkg::PH_HUNT;
            remain_reg  <= 16'd0;
            pidx_reg    <= 16'd0;
            fid_reg     <= 8'd0;
            finstr_reg  <= 8'd0;
            fcount_reg  <= 16'd0;
            crc_lo_reg  <= 8'd0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            pidx_reg    <= pidx_next;
            fid_reg     <= fid_next;
            finstr_reg  <= finstr_next;
            fcount_reg  <= fcount_next;
            crc_lo_reg  <= crc_lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_byte_reg <= s_byte_value;
        end
        if (process && emit) begin
            out_ev_reg    <= out_ev_next;
            out_id_reg    <= out_id_next;
            out_instr_reg <= out_instr_next;
            out_pidx_reg  <= out_pidx_next;
            out_pbyte_reg <= out_pbyte_next;
            out_count_reg <= out_count_next;
            out_crc_reg   <= out_crc_next;
        end
    end

    assign m_valid            = out_vld_reg;
    assign m_event_res        = out_ev_reg;
    assign m_servo_id         = out_id_reg;
    assign m_instruction_code = out_instr_reg;
    assign m_param_index      = out_pidx_reg;
    assign m_param_byte       = out_pbyte_reg;
    assign m_param_count      = out_count_reg;
    assign m_crc_received     = out_crc_reg;

endmodule

>>> tb/servo_frame_check_pkg.sv
// Expected-event tracking for the servo packet receive parser testbench.
// Holds a cycle-free frame parser that predicts each event, and the queue that checks them.
// Depends on sprp_pkg for the phase type, the event codes and the frame constants.
package servo_frame_check_pkg;
    import sprp_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct {
        event_t      ev;
        logic [7:0]  servo_id;
        logic [7:0]  instruction;
        logic [15:0] param_index;
        logic [7:0]  param_byte;
        logic [15:0] param_count;
        logic [15:0] crc;
    } frame_event_t;

    class frame_event_tracker;
        logic [7:0]   id_regs [2];
        phase_t       phase;
        logic [15:0]  remaining;
        logic [15:0]  param_index;
        logic [7:0]   frame_id;
        logic [7:0]   frame_instr;
        logic [15:0]  param_count;
        logic [7:0]   crc_low;
        frame_event_t expected_events [$];
        int unsigned  mismatches;

        function new();
            id_regs[REG_FIRST_ID]  = FIRST_ID_RESET;
            id_regs[REG_SECOND_ID] = SECOND_ID_RESET;
            phase       = PH_HUNT;
            remaining   = '0;
            param_index = '0;
            frame_id    = '0;
            frame_instr = '0;
            param_count = '0;
            crc_low     = '0;
            mismatches  = 0;
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        function void add_event(event_t ev, logic [15:0] idx, logic [7:0] pbyte,
                                logic [15:0] cnt, logic [15:0] crc);
            frame_event_t e;
            e.ev          = ev;
            e.servo_id    = frame_id;
            e.instruction = frame_instr;
            e.param_index = idx;
            e.param_byte  = pbyte;
            e.param_count = cnt;
            e.crc         = crc;
            expected_events.push_back(e);
        endfunction

        function void abort_frame();
            add_event(EV_ABORT, '0, '0, '0, '0);
            phase = PH_HUNT;
        endfunction

        // Advances the parse by one accepted request.
        function void note_request(logic kind, logic [7:0] b);
            logic [15:0] len;
            if (phase == PH_HUNT) begin
                if (kind == KIND_BYTE && b == HDR_BYTE_FF) begin
                    frame_id    = '0;
                    frame_instr = '0;
                    param_index = '0;
                    phase       = PH_HDR_FF;
                end
                return;
            end
            if (kind == KIND_IDLE) begin
                abort_frame();
                return;
            end
            case (phase)
                PH_HDR_FF: begin
                    if (b == HDR_BYTE_FF) phase = PH_HDR_FD;
                    else abort_frame();
                end
                PH_HDR_FD: begin
                    if (b == HDR_BYTE_FD) phase = PH_HDR_00;
                    else abort_frame();
                end
                PH_HDR_00: begin
                    if (b == HDR_BYTE_00) phase = PH_ID;
                    else abort_frame();
                end
                PH_ID: begin
                    if (b == id_regs[REG_FIRST_ID] || b == id_regs[REG_SECOND_ID]) begin
                        frame_id = b;
                        phase    = PH_LEN_LO;
                    end else begin
                        abort_frame();
                    end
                end
                PH_LEN_LO: begin
                    remaining = {8'h00, b};
                    phase     = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len = {b, remaining[7:0]};
                    if (len < MIN_LENGTH) begin
                        abort_frame();
                    end else begin
                        remaining   = len;
                        param_count = len - MIN_LENGTH;
                        phase       = PH_INSTR;
                    end
                end
                PH_INSTR: begin
                    frame_instr = b;
                    remaining   = remaining - 16'd1;
                    phase       = (remaining == CRC_BYTES) ? PH_CRC_LO : PH_PARAM;
                end
                PH_PARAM: begin
                    add_event(EV_PARAM, param_index, b, '0, '0);
                    param_index = param_index + 16'd1;
                    remaining   = remaining - 16'd1;
                    if (remaining == CRC_BYTES) phase = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    crc_low = b;
                    phase   = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    add_event(EV_DONE, '0, '0, param_count, {b, crc_low});
                    phase = PH_HUNT;
                end
                default: begin
                    phase = PH_HUNT;
                end
            endcase
        endfunction

        function string describe(frame_event_t e);
            return $sformatf("event %0d id %02h instr %02h index %0d byte %02h count %0d crc %04h",
                             e.ev, e.servo_id, e.instruction, e.param_index, e.param_byte,
                             e.param_count, e.crc);
        endfunction

        function void check_result(frame_event_t got);
            frame_event_t want;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: %s", describe(got));
                return;
            end
            want = expected_events.pop_front();
            if (got.ev !== want.ev || got.servo_id !== want.servo_id ||
                got.instruction !== want.instruction ||
                got.param_index !== want.param_index ||
                got.param_byte !== want.param_byte ||
                got.param_count !== want.param_count || got.crc !== want.crc) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result mismatch, expected: %s", describe(want));
                    $display("                  actual: %s", describe(got));
                end
            end
        endfunction
    endclass

endpackage

>>> tb/tb_top.sv
// Top-level testbench for the servo packet receive parser.
// Drives serial requests and ID register writes, and checks every result against a prediction.
// Depends on sprp_pkg and servo_frame_check_pkg.
module tb_top;
    import sprp_pkg::*;
    import servo_frame_check_pkg::*;

    // Roughly this many requests are sent in each random segment; six segments in all.
    localparam int unsigned SEGMENT_ITEMS = 170;
    localparam int unsigned SEGMENTS      = 6;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic        s_kind       = KIND_BYTE;
    logic [7:0]  s_byte_value = 8'h00;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [1:0]  m_event_res;
    logic [7:0]  m_servo_id;
    logic [7:0]  m_instruction_code;
    logic [15:0] m_param_index;
    logic [7:0]  m_param_byte;
    logic [15:0] m_param_count;
    logic [15:0] m_crc_received;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    frame_event_tracker tracker;
    frame_event_t       seen_event;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        items_sent    = 0;

    servo_packet_receive_parser uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_byte_value       (s_byte_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_res        (m_event_res),
        .m_servo_id         (m_servo_id),
        .m_instruction_code (m_instruction_code),
        .m_param_index      (m_param_index),
        .m_param_byte       (m_param_byte),
        .m_param_count      (m_param_count),
        .m_crc_received     (m_crc_received),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #5 aclk = ~aclk;

    // The receiver stalls at random; with a zero percentage it takes every result at once.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both handshakes are sampled on the clock edge, so the values seen here are the ones
    // that held just before it. The result is checked before the new request is noted,
    // although a request just noted has no result yet, so the order does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_event.ev          = event_t'(m_event_res);
                seen_event.servo_id    = m_servo_id;
                seen_event.instruction = m_instruction_code;
                seen_event.param_index = m_param_index;
                seen_event.param_byte  = m_param_byte;
                seen_event.param_count = m_param_count;
                seen_event.crc         = m_crc_received;
                tracker.check_result(seen_event);
            end
            if (s_valid && s_ready)
                tracker.note_request(s_kind, s_byte_value);
        end
    end

    // Sends one request. The sender may first idle at random; once valid is raised
    // it stays high with the same payload until the request has been taken.
    task automatic send_item(logic kind, logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_byte_value <= value;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_byte_list(logic [7:0] frame_bytes [$]);
        foreach (frame_bytes[i]) send_item(KIND_BYTE, frame_bytes[i]);
    endtask

    // Lets the pipeline empty: every expected result has arrived and a request that
    // yields no result has had time to pass through the parsing stage as well.
    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // A write takes a setup phase and an access phase; pready is always high, so the
    // register takes the value at the end of the access phase.
    task automatic write_servo_id(logic reg_idx, logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {24'h000000, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.id_regs[reg_idx] = value;
    endtask

    // The directed part runs with the reset IDs of 1 and 2.
    task automatic run_directed_frames();
        logic [7:0] frame_bytes [$];
        // An idle mark while hunting starts nothing, even with FF left on the byte lines,
        // and neither does a stray byte other than FF.
        send_item(KIND_IDLE, HDR_BYTE_FF);
        send_item(KIND_BYTE, 8'h55);
        // A complete frame to the second ID with the extreme instruction and parameter
        // values: two parameters, 00 and FF, and a CRC of FF00.
        frame_bytes = '{HDR_BYTE_FF, HDR_BYTE_FF, HDR_BYTE_FD, HDR_BYTE_00, SECOND_ID_RESET,
                        8'h05, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        send_byte_list(frame_bytes);
        // A length of two is too short and is aborted.
        frame_bytes = '{HDR_BYTE_FF, HDR_BYTE_FF, HDR_BYTE_FD, HDR_BYTE_00, FIRST_ID_RESET,
                        8'h02, 8'h00};
        send_byte_list(frame_bytes);
        // The line going idle right after the first header byte.
        send_item(KIND_BYTE, HDR_BYTE_FF);
        send_item(KIND_IDLE, 8'h00);
        // A wrong second header byte.
        frame_bytes = '{HDR_BYTE_FF, 8'hFE};
        send_byte_list(frame_bytes);
        // An ID that matches neither register.
        frame_bytes = '{HDR_BYTE_FF, HDR_BYTE_FF, HDR_BYTE_FD, HDR_BYTE_00, 8'h07};
        send_byte_list(frame_bytes);
    endtask

    // Builds one frame with random content, mostly well formed. A quarter of the frames
    // are damaged: a byte is replaced, turned into an idle mark, or the frame is cut
    // short, which leaves the parser mid-frame for whatever follows.
    task automatic send_random_frame();
        logic [8:0]  items [$];
        int unsigned pick;
        int unsigned pos;
        logic [7:0]  id;
        logic [15:0] len;
        pick = $urandom_range(9);
        if (pick < 4) id = tracker.id_regs[REG_FIRST_ID];
        else if (pick < 8) id = tracker.id_regs[REG_SECOND_ID];
        else id = 8'($urandom);
        // Short lengths now and then, a frame of a few hundred parameters rarely,
        // otherwise small frames including those with no parameters.
        pick = $urandom_range(99);
        if (pick < 4) len = 16'($urandom_range(2));
        else if (pick < 6) len = 16'($urandom_range(300, 250)) + MIN_LENGTH;
        else len = 16'($urandom_range(12)) + MIN_LENGTH;
        items.push_back({KIND_BYTE, HDR_BYTE_FF});
        items.push_back({KIND_BYTE, HDR_BYTE_FF});
        items.push_back({KIND_BYTE, HDR_BYTE_FD});
        items.push_back({KIND_BYTE, HDR_BYTE_00});
        items.push_back({KIND_BYTE, id});
        items.push_back({KIND_BYTE, len[7:0]});
        items.push_back({KIND_BYTE, len[15:8]});
        if (len >= MIN_LENGTH) begin
            // Instruction, parameters and two CRC bytes: len bytes in all.
            repeat (len) items.push_back({KIND_BYTE, 8'($urandom)});
        end
        if ($urandom_range(99) < 25) begin
            pos = $urandom_range(items.size() - 1);
            case ($urandom_range(2))
                0: items[pos] = {items[pos][8], 8'($urandom)};
                1: items[pos] = {KIND_IDLE, items[pos][7:0]};
                default: begin
                    while (items.size() > pos + 1) void'(items.pop_back());
                end
            endcase
        end
        // Line noise between frames: random bytes and idle marks.
        if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(3, 1)) send_item(1'($urandom), 8'($urandom));
        end
        foreach (items[i]) send_item(items[i][8], items[i][7:0]);
    endtask

    initial begin
        int unsigned drain_cycles;
        tracker = new();
        send_idle_pct = 33;
        recv_idle_pct = 54;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed_frames();

        // Each pair of segments shares one pattern of idling: first the sender idles less
        // than the receiver stalls, then the other way round, then neither holds back.
        // The IDs change between segments, extremes and equal values among them.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_for_quiet();
            case (seg / 2)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 54;
                end
                1: begin
                    send_idle_pct = 54;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (seg)
                0: begin
                    write_servo_id(REG_FIRST_ID, 8'h00);
                    write_servo_id(REG_SECOND_ID, 8'hFF);
                end
                1: begin
                    write_servo_id(REG_FIRST_ID, 8'hFF);
                    write_servo_id(REG_SECOND_ID, 8'h00);
                end
                3: begin
                    write_servo_id(REG_FIRST_ID, HDR_BYTE_FD);
                    write_servo_id(REG_SECOND_ID, HDR_BYTE_FD);
                end
                5: begin
                    write_servo_id(REG_FIRST_ID, FIRST_ID_RESET);
                    write_servo_id(REG_SECOND_ID, SECOND_ID_RESET);
                end
                default: begin
                    write_servo_id(REG_FIRST_ID, 8'($urandom));
                    write_servo_id(REG_SECOND_ID, 8'($urandom));
                end
            endcase
            items_sent = 0;
            while (items_sent < SEGMENT_ITEMS) send_random_frame();
        end

        // Wait for the last results, then idle on so that a stray extra result would still be caught.
        s_valid <= 1'b0;
        drain_cycles = 0;
        while (tracker.pending() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (8) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
